@@ hw/rtl/button_debounce_multitap_combo_assert.svh @@
// Assertion macros for the button debounce / multi-tap / combo block.
// Used by button_debounce_multitap_combo.sv; expects clk and rst_n in scope.
`ifndef BUTTON_DEBOUNCE_MULTITAP_COMBO_ASSERT_SVH
`define BUTTON_DEBOUNCE_MULTITAP_COMBO_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset.
`define BDMC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked out of reset.
`define BDMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BDMC_ASSERT_IMPLY(lbl, ante, cons, msg)
`define BDMC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ hw/rtl/bdmc_pkg.sv @@
// Package for the button debounce / multi-tap / combo block: event codes,
// configuration indexes, register widths and reset values. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bdmc_pkg;

  localparam int CODE_W  = 3;
  localparam int TAP_W   = 3;
  localparam int STAMP_W = 32;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int ENABLE_W  = 7;

  typedef enum logic [CODE_W-1:0] {
    EV_NONE    = 3'd0,
    EV_COMBO21 = 3'd1,
    EV_COMBO31 = 3'd2,
    EV_BTN2    = 3'd3,
    EV_BTN3    = 3'd4,
    EV_DOUBLE  = 3'd5,
    EV_TRIPLE  = 3'd6,
    EV_QUAD    = 3'd7
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE_TIME = 2'd0,
    CFG_TAP_TIMEOUT   = 2'd1,
    CFG_EVENT_ENABLE  = 2'd2,
    CFG_UNUSED        = 2'd3
  } cfg_index_t;

  localparam logic [CFG_W-1:0]    DEBOUNCE_RESET = 16'd50;
  localparam logic [CFG_W-1:0]    TIMEOUT_RESET  = 16'd300;
  localparam logic [ENABLE_W-1:0] ENABLE_RESET   = 7'h7f;
  localparam logic [TAP_W-1:0]    TAP_MAX        = 3'd7;

endpackage

`default_nettype wire

@@ hw/rtl/button_debounce_multitap_combo.sv @@
// Button poller: debounce on button 1, multi-tap counting and combo events.
// Depends on bdmc_pkg and button_debounce_multitap_combo_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "button_debounce_multitap_combo_assert.svh"

// A poll taken into stage 1 moves on into the result register, out_valid high,
//   unless an output stall holds it in stage 1. Throughput: one poll per cycle
//   while not stalled; set by the single pass from the poll register through two
//   TIME_BITS-wide subtract/compare paths into the result register.
// Reset (rst_n low, synchronous): both pipeline stages empty, debounce and tap
//   state cleared, debounce_time = 50, tap_timeout = 300, event_enable = 0x7f.
module button_debounce_multitap_combo #(
  parameter int TIME_BITS = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // configuration write port
  input  wire logic                                 cfg_we,
  input  wire logic [bdmc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [bdmc_pkg::CFG_W-1:0]           cfg_wdata,
  // poll channel
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 in_level_one,
  input  wire logic                                 in_level_two,
  input  wire logic                                 in_level_three,
  input  wire logic [bdmc_pkg::STAMP_W-1:0]         in_now_ms,
  // result channel
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [bdmc_pkg::CODE_W-1:0]               out_event_code,
  output logic                                      out_debounced_one,
  output logic [bdmc_pkg::TAP_W-1:0]                out_taps_pending
);
  import bdmc_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers. Write only while the block is idle; not enforced here.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0]    debounce_time_r;
  logic [CFG_W-1:0]    tap_timeout_r;
  logic [ENABLE_W-1:0] event_enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_time_r <= DEBOUNCE_RESET;
      tap_timeout_r   <= TIMEOUT_RESET;
      event_enable_r  <= ENABLE_RESET;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_DEBOUNCE_TIME: debounce_time_r <= cfg_wdata;
        CFG_TAP_TIMEOUT:   tap_timeout_r   <= cfg_wdata;
        CFG_EVENT_ENABLE:  event_enable_r  <= cfg_wdata[ENABLE_W-1:0];
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake. Stage 1 holds the accepted poll; the result register parts the
  // two sides, so a new poll is taken while a finished result waits.
  // ---------------------------------------------------------------------------
  logic                s1_valid_r;
  logic                s1_one_r, s1_two_r, s1_three_r;
  logic [STAMP_W-1:0]  s1_now_r;
  logic                out_valid_r;
  logic                out_load;
  logic                in_accept;

  // load the result register when stage 1 is full and the output is free
  assign out_load  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !out_load;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (out_load) begin
      s1_valid_r <= 1'b0;
    end
  end

  // poll payload: no reset needed
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_one_r   <= in_level_one;
      s1_two_r   <= in_level_two;
      s1_three_r <= in_level_three;
      s1_now_r   <= in_now_ms;
    end
  end

  // ---------------------------------------------------------------------------
  // Debounce and tap state. Updated only when a transaction moves into the
  // result register, so items are processed strictly in order.
  // ---------------------------------------------------------------------------
  logic                 prev_raw_r,  prev_raw_nxt;
  logic [TIME_BITS-1:0] stable_r,    stable_nxt;
  logic                 accepted_r,  accepted_nxt;
  logic [TAP_W-1:0]     taps_r,      taps_nxt;
  logic [TIME_BITS-1:0] press_r,     press_nxt;

  logic [TIME_BITS-1:0] now_t;
  logic                 raw_change;
  logic [TIME_BITS-1:0] stable_elapsed;
  logic [TIME_BITS-1:0] press_elapsed;
  logic                 level_accept;
  logic                 new_press;
  logic [TAP_W-1:0]     taps_pressed;
  logic                 tap_expired;
  event_t               code_raw;
  event_t               code_tap;
  event_t               code_final;
  logic [TAP_W-1:0]     enable_idx;

  // timestamps wrap modulo 2^TIME_BITS
  assign now_t = TIME_BITS'(s1_now_r);

  always_comb begin
    // debounce: a raw change restarts the stamp, so elapsed time is zero
    raw_change     = (s1_one_r != prev_raw_r);
    stable_nxt     = raw_change ? now_t : stable_r;
    stable_elapsed = raw_change ? '0 : (now_t - stable_r);
    level_accept   = (stable_elapsed > TIME_BITS'(debounce_time_r))
                     && (s1_one_r != accepted_r);
    accepted_nxt   = level_accept ? s1_one_r : accepted_r;
    new_press      = level_accept && s1_one_r;
    prev_raw_nxt   = s1_one_r;

    // count the press, saturating at the maximum
    taps_pressed = taps_r;
    if (new_press && (taps_r != TAP_MAX)) begin
      taps_pressed = taps_r + TAP_W'(1);
    end
    // a fresh press sets the stamp to now, so its elapsed time is zero
    press_elapsed = new_press ? '0 : (now_t - press_r);
    tap_expired   = !accepted_nxt && (taps_pressed != '0)
                    && (press_elapsed > TIME_BITS'(tap_timeout_r));

    // combos and single buttons, highest priority first
    if (accepted_nxt && s1_two_r) begin
      code_raw = EV_COMBO21;
    end else if (accepted_nxt && s1_three_r) begin
      code_raw = EV_COMBO31;
    end else if (s1_two_r) begin
      code_raw = EV_BTN2;
    end else if (s1_three_r) begin
      code_raw = EV_BTN3;
    end else begin
      code_raw = EV_NONE;
    end

    // tap classification; counts of one or five and up report nothing
    case (taps_pressed)
      3'd2:    code_tap = EV_DOUBLE;
      3'd3:    code_tap = EV_TRIPLE;
      3'd4:    code_tap = EV_QUAD;
      default: code_tap = EV_NONE;
    endcase

    taps_nxt   = taps_pressed;
    press_nxt  = new_press ? now_t : press_r;
    code_final = code_raw;
    if (code_raw != EV_NONE) begin
      // button events clear the taps and the press stamp
      taps_nxt  = '0;
      press_nxt = '0;
    end else if (tap_expired) begin
      // timeout clear leaves the press stamp alone
      code_final = code_tap;
      taps_nxt   = '0;
    end

    // disabled events report nothing; state still moves as above
    enable_idx = TAP_W'(code_final) - TAP_W'(1);
    if ((code_final != EV_NONE) && !event_enable_r[enable_idx]) begin
      code_final = EV_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_raw_r <= 1'b0;
      stable_r   <= '0;
      accepted_r <= 1'b0;
      taps_r     <= '0;
      press_r    <= '0;
    end else if (out_load) begin
      prev_raw_r <= prev_raw_nxt;
      stable_r   <= stable_nxt;
      accepted_r <= accepted_nxt;
      taps_r     <= taps_nxt;
      press_r    <= press_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: hold while stalled, advance on load.
  // ---------------------------------------------------------------------------
  logic [CODE_W-1:0] out_code_r;
  logic              out_deb_r;
  logic [TAP_W-1:0]  out_taps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_code_r <= code_final;
      out_deb_r  <= accepted_nxt;
      out_taps_r <= taps_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_code    = out_code_r;
  assign out_debounced_one = out_deb_r;
  assign out_taps_pending  = out_taps_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `BDMC_ASSERT_IMPLY(a_button_event_clears_taps,
    out_valid && (out_event_code == EV_COMBO21 || out_event_code == EV_COMBO31 ||
    out_event_code == EV_BTN2 || out_event_code == EV_BTN3),
    out_taps_pending == '0, "button event left taps pending")
  `BDMC_ASSERT_IMPLY(a_tap_event_released,
    out_valid && (out_event_code == EV_DOUBLE || out_event_code == EV_TRIPLE ||
    out_event_code == EV_QUAD),
    (out_taps_pending == '0) && !out_debounced_one, "tap event while pressed or pending")
  `BDMC_ASSERT_IMPLY(a_stall_only_when_full, in_stall,
    s1_valid_r && out_valid_r && out_stall, "input stalled without a full pipeline")
  `BDMC_ASSERT_NEXT(a_state_holds_idle, !out_load,
    $stable(taps_r) && $stable(accepted_r), "tap state moved without a transaction")

endmodule

`default_nettype wire
